// ----- hdl/xrng_pkg.sv -----
// ----------------------------------------------------------------------------
// xrng_pkg: shared types and constants for the bounded xoshiro256++ generator
// Holds the controller state type, the command and status structs and the constants.
// ----------------------------------------------------------------------------
package xrng_pkg;

    localparam int unsigned WordW = 64;

    localparam logic [63:0] SmGamma = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SmMul1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SmMul2  = 64'h94D049BB133111EB;

    localparam logic [255:0] JumpPoly = {64'h39ABDC4529B1661C, 64'hA9582618E03FC9AA,
                                         64'hD5A61266F0C9392C, 64'h180EC6D33CFD0ABA};

    localparam logic [1:0] KindDraw   = 2'd0;
    localparam logic [1:0] KindJump   = 2'd1;
    localparam logic [1:0] KindReseed = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_SEED, S_SM_A, S_SM_B, S_SM_C, S_SM_D, S_SM_E,
        S_LIM, S_DIV, S_DRAW, S_RDIV, S_JUMP, S_JEND, S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture item, clear state for result
        logic sm_init;   // load splitmix counter from seed
        logic sm_add;    // counter += gamma, z <= counter ^ counter>>30
        logic sm_mul1;   // one partial product of z * mul1
        logic sm_mix2;   // z ^= z>>27
        logic sm_mul2;   // one partial product of z * mul2
        logic sm_store;  // store z ^ z>>31 into state word
        logic div_start; // start divider on (-range, range)
        logic div_step;  // one restoring step
        logic gen;       // advance generator
        logic rdiv_start;// start divider on (word, range)
        logic jump_clr;  // clear jump accumulator
        logic jump_step; // accumulate (if poly bit) and advance
        logic jump_end;  // copy accumulator to state
        logic set_val;   // form result from divider remainder
        logic set_full;  // result is origin + word masked
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       range_zero_or_pow2;
        logic       div_done;
        logic       accept;
        logic       sm_last;
        logic       mul_done;
        logic       jump_last;
    } t_stat;

endpackage

// ----- hdl/xrng_ctrl.sv -----
// ----------------------------------------------------------------------------
// xrng_ctrl: sequencer for the bounded generator
// Steps the datapath through splitmix seeding, jumps, divisions and draws.
// ----------------------------------------------------------------------------
module xrng_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_out_fire,
    input  xrng_pkg::t_stat i_stat,
    output xrng_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_valid
);

    xrng_pkg::t_state r_state, n_state;
    logic             r_boot, n_boot;

    // State register; the expansion after reset gives no result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xrng_pkg::S_SEED;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_boot  = r_boot;
        case (r_state)
            xrng_pkg::S_IDLE: begin
                if (i_in_fire) begin
                    case (i_stat.kind)
                        xrng_pkg::KindDraw: begin
                            n_state = i_stat.range_zero_or_pow2 ? xrng_pkg::S_DRAW
                                                                : xrng_pkg::S_LIM;
                        end
                        xrng_pkg::KindJump:   n_state = xrng_pkg::S_JUMP;
                        xrng_pkg::KindReseed: n_state = xrng_pkg::S_SEED;
                        default:              n_state = xrng_pkg::S_OUT;
                    endcase
                end
            end
            xrng_pkg::S_SEED: n_state = xrng_pkg::S_SM_A;
            xrng_pkg::S_SM_A: n_state = xrng_pkg::S_SM_B;
            xrng_pkg::S_SM_B: n_state = i_stat.mul_done ? xrng_pkg::S_SM_C : xrng_pkg::S_SM_B;
            xrng_pkg::S_SM_C: n_state = xrng_pkg::S_SM_D;
            xrng_pkg::S_SM_D: n_state = i_stat.mul_done ? xrng_pkg::S_SM_E : xrng_pkg::S_SM_D;
            xrng_pkg::S_SM_E: begin
                if (i_stat.sm_last) begin
                    n_state = r_boot ? xrng_pkg::S_IDLE : xrng_pkg::S_OUT;
                    n_boot  = 1'b0;
                end else begin
                    n_state = xrng_pkg::S_SM_A;
                end
            end
            xrng_pkg::S_LIM:  n_state = xrng_pkg::S_DIV;
            xrng_pkg::S_DIV:  n_state = i_stat.div_done ? xrng_pkg::S_DRAW : xrng_pkg::S_DIV;
            xrng_pkg::S_DRAW: begin
                if (i_stat.range_zero_or_pow2) begin
                    n_state = xrng_pkg::S_OUT;
                end else if (i_stat.accept) begin
                    n_state = xrng_pkg::S_RDIV;
                end
            end
            xrng_pkg::S_RDIV: n_state = i_stat.div_done ? xrng_pkg::S_OUT : xrng_pkg::S_RDIV;
            xrng_pkg::S_JUMP: n_state = i_stat.jump_last ? xrng_pkg::S_JEND : xrng_pkg::S_JUMP;
            xrng_pkg::S_JEND: n_state = xrng_pkg::S_OUT;
            xrng_pkg::S_OUT:  n_state = i_out_fire ? xrng_pkg::S_IDLE : xrng_pkg::S_OUT;
            default:          n_state = xrng_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            xrng_pkg::S_IDLE: begin
                o_busy   = 1'b0;
                o_cmd.load = i_in_fire;
                o_cmd.jump_clr = i_in_fire;
                o_cmd.div_start = i_in_fire;
            end
            xrng_pkg::S_SEED: o_cmd.sm_init = 1'b1;
            xrng_pkg::S_SM_A: o_cmd.sm_add  = 1'b1;
            xrng_pkg::S_SM_B: o_cmd.sm_mul1 = 1'b1;
            xrng_pkg::S_SM_C: o_cmd.sm_mix2 = 1'b1;
            xrng_pkg::S_SM_D: o_cmd.sm_mul2 = 1'b1;
            xrng_pkg::S_SM_E: o_cmd.sm_store = 1'b1;
            xrng_pkg::S_LIM:  o_cmd.div_step = 1'b0;
            xrng_pkg::S_DIV:  o_cmd.div_step = 1'b1;
            xrng_pkg::S_DRAW: begin
                o_cmd.gen = 1'b1;
                o_cmd.set_full = i_stat.range_zero_or_pow2;
                o_cmd.rdiv_start = ~i_stat.range_zero_or_pow2 & i_stat.accept;
            end
            xrng_pkg::S_RDIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.set_val  = i_stat.div_done;
            end
            xrng_pkg::S_JUMP: o_cmd.jump_step = 1'b1;
            xrng_pkg::S_JEND: o_cmd.jump_end  = 1'b1;
            xrng_pkg::S_OUT:  o_valid = 1'b1;
            default:          o_busy  = 1'b1;
        endcase
    end

endmodule

// ----- hdl/xrng_dp.sv -----
// ----------------------------------------------------------------------------
// xrng_dp: datapath of the bounded generator
// Generator state, splitmix expander, jump accumulator, serial divider.
// ----------------------------------------------------------------------------
module xrng_dp (
    input  logic                        i_clk,
    input  xrng_pkg::t_cmd              i_cmd,
    input  logic [1:0]                  i_kind,
    input  logic [xrng_pkg::WordW-1:0]  i_origin,
    input  logic [xrng_pkg::WordW-1:0]  i_bound,
    input  logic [xrng_pkg::WordW-1:0]  i_seed,
    output xrng_pkg::t_stat             o_stat,
    output logic [xrng_pkg::WordW-1:0]  o_value
);

    localparam int unsigned W  = xrng_pkg::WordW;
    localparam int unsigned CW = $clog2(W);

    logic [63:0]   r_s0, r_s1, r_s2, r_s3;
    logic [63:0]   r_a0, r_a1, r_a2, r_a3;
    logic [63:0]   r_x, r_z, r_limit;
    logic [63:0]   r_origin, r_range, r_value;
    logic [1:0]    r_kind;
    logic [1:0]    r_sm_idx;
    logic [7:0]    r_jcnt;
    // divider
    logic [63:0]   r_quo, r_rem;
    logic [CW:0]   r_dcnt;
    // splitmix multiplier, three 32x32 partial products
    logic [1:0]    r_mph;
    logic [63:0]   r_macc;

    logic [63:0] g_out, g0, g1, g2, g3, t, rng_in;
    logic [64:0] rem_sh;
    logic [63:0] rem_sub;
    logic        rem_ge;
    logic [63:0] mul_k, mul_p, mul_sum;
    logic [31:0] mul_a, mul_b;

    assign rng_in = i_bound - i_origin;

    // xoshiro256++ step
    always_comb begin
        logic [63:0] sum, c3;
        sum   = r_s0 + r_s3;
        g_out = {sum[40:0], sum[63:41]} + r_s0;
        t     = r_s1 << 17;
        g2    = r_s2 ^ r_s0;
        c3    = r_s3 ^ r_s1;
        g1    = r_s1 ^ g2;
        g0    = r_s0 ^ c3;
        g2    = g2 ^ t;
        g3    = {c3[18:0], c3[63:19]};
    end

    // restoring divider step: dividend shifts out of r_quo
    assign rem_sh  = {r_rem, r_quo[63]};
    assign rem_ge  = rem_sh >= {1'b0, r_range};
    assign rem_sub = rem_ge ? 64'(rem_sh - {1'b0, r_range}) : rem_sh[63:0];

    // low 64 bits of z * k: lo*lo, then lo*hi and hi*lo shifted up by 32
    assign mul_k   = i_cmd.sm_mul1 ? xrng_pkg::SmMul1 : xrng_pkg::SmMul2;
    assign mul_a   = (r_mph == 2'd2) ? r_z[63:32] : r_z[31:0];
    assign mul_b   = (r_mph == 2'd1) ? mul_k[63:32] : mul_k[31:0];
    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign mul_sum = r_macc + {mul_p[31:0], 32'd0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_origin <= i_origin;
            r_range  <= rng_in;
            r_value  <= '0;
            r_limit  <= '0;
        end
        if (i_cmd.div_start) begin
            r_quo  <= 64'(0) - rng_in;
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.rdiv_start) begin
            r_quo  <= g_out;
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo  <= {r_quo[62:0], rem_ge};
            r_rem  <= rem_sub;
            r_dcnt <= r_dcnt + 1'b1;
            if (r_dcnt == (CW+1)'(W-1) && r_kind == xrng_pkg::KindDraw)
                r_limit <= rem_sub;
        end
        // splitmix64 expansion, each multiply built up over the r_mph phases
        if (i_cmd.sm_init) begin
            r_x      <= i_seed;
            r_sm_idx <= '0;
        end
        if (i_cmd.sm_add) begin
            r_x   <= r_x + xrng_pkg::SmGamma;
            r_z   <= (r_x + xrng_pkg::SmGamma) ^ ((r_x + xrng_pkg::SmGamma) >> 30);
            r_mph <= '0;
        end
        if (i_cmd.sm_mul1 || i_cmd.sm_mul2) begin
            r_mph <= r_mph + 2'd1;
            if (r_mph == 2'd0) r_macc <= mul_p;
            else               r_macc <= mul_sum;
            if (r_mph == 2'd2) r_z <= mul_sum;
        end
        if (i_cmd.sm_mix2) begin
            r_z   <= r_z ^ (r_z >> 27);
            r_mph <= '0;
        end
        if (i_cmd.sm_store) begin
            r_sm_idx <= r_sm_idx + 1'b1;
            case (r_sm_idx)
                2'd0:    r_s0 <= r_z ^ (r_z >> 31);
                2'd1:    r_s1 <= r_z ^ (r_z >> 31);
                2'd2:    r_s2 <= r_z ^ (r_z >> 31);
                default: r_s3 <= r_z ^ (r_z >> 31);
            endcase
        end
        // generator advance (draw or jump)
        if (i_cmd.gen || i_cmd.jump_step) begin
            r_s0   <= g0;
            r_s1   <= g1;
            r_s2   <= g2;
            r_s3   <= g3;
        end
        if (i_cmd.jump_clr) begin
            r_a0 <= '0; r_a1 <= '0; r_a2 <= '0; r_a3 <= '0;
            r_jcnt <= '0;
        end
        if (i_cmd.jump_step) begin
            r_jcnt <= r_jcnt + 1'b1;
            if (xrng_pkg::JumpPoly[r_jcnt]) begin
                r_a0 <= r_a0 ^ r_s0; r_a1 <= r_a1 ^ r_s1;
                r_a2 <= r_a2 ^ r_s2; r_a3 <= r_a3 ^ r_s3;
            end
        end
        if (i_cmd.jump_end) begin
            r_s0 <= r_a0; r_s1 <= r_a1; r_s2 <= r_a2; r_s3 <= r_a3;
        end
        if (i_cmd.set_full) r_value <= r_origin + (g_out & (r_range - 1'b1));
        if (i_cmd.set_val)  r_value <= r_origin + rem_sub;
    end

    assign o_stat.kind      = i_cmd.load ? i_kind : r_kind;
    assign o_stat.range_zero_or_pow2 = i_cmd.load ? ((rng_in & (rng_in - 1'b1)) == '0)
                                                  : ((r_range & (r_range - 1'b1)) == '0);
    assign o_stat.div_done  = r_dcnt == (CW+1)'(W-1);
    assign o_stat.accept    = g_out >= r_limit;
    assign o_stat.sm_last   = r_sm_idx == 2'd3;
    assign o_stat.mul_done  = r_mph == 2'd2;
    assign o_stat.jump_last = r_jcnt == 8'd255;
    assign o_value          = r_value;

endmodule

// ----- hdl/xoshiro256pp_bounded_rng.sv -----
// ----------------------------------------------------------------------------
// xoshiro256pp_bounded_rng: bounded draws from a xoshiro256++ generator
// Top level: streaming ports, seed register, controller and datapath.
// ----------------------------------------------------------------------------
// One item at a time; each item gives one result, and no new item is taken
// until that result has been taken. A draw over a zero or power-of-two range
// masks a single generator word; any other draw runs the bit-serial 64-step
// divider once for the rejection limit and once for the final remainder,
// drawing a new word for each rejected one. A jump takes one generator step
// per polynomial bit, a reseed four splitmix outputs, each with two
// multiplies done as three 32x32 partial products. After reset the state is
// expanded from seed zero, so the input is not ready until that expansion ends.
module xoshiro256pp_bounded_rng (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [xrng_pkg::WordW-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [2*xrng_pkg::WordW-1:0]  s_axis_tdata,  // origin, bound
    input  logic [1:0]                    s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [xrng_pkg::WordW-1:0]    m_axis_tdata   // value
);

    localparam int unsigned W = xrng_pkg::WordW;

    xrng_pkg::t_cmd  w_cmd;
    xrng_pkg::t_stat w_stat;
    logic            w_busy, w_in_fire, w_out_fire;
    logic [W-1:0]    r_seed;

    // Seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = ~w_busy;
    assign w_in_fire     = s_axis_tvalid & s_axis_tready;
    assign w_out_fire    = m_axis_tvalid & m_axis_tready;

    xrng_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_out_fire (w_out_fire),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy),
        .o_valid    (m_axis_tvalid)
    );

    xrng_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_kind   (s_axis_tuser),
        .i_origin (s_axis_tdata[W-1:0]),
        .i_bound  (s_axis_tdata[2*W-1:W]),
        .i_seed   (r_seed),
        .o_stat   (w_stat),
        .o_value  (m_axis_tdata)
    );

    // No input accepted while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");

    // Result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed before transaction");

endmodule
